// ===== sv/rsp_packet_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// rsp_packet_deframer_defines
// Assertion macros used by the deframer checker, rpd_checker.
// ----------------------------------------------------------------------------
`ifndef RSP_PACKET_DEFRAMER_DEFINES_SVH
`define RSP_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpd assertion failed");

// Next-cycle implication, checked outside reset
`define RPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpd assertion failed");

`endif

// ===== sv/rpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg
// Codes, characters and helper types for the debug-link packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PAYLOAD = 3'd1;
    localparam logic [2:0] EV_GOOD    = 3'd2;
    localparam logic [2:0] EV_BAD     = 3'd3;
    localparam logic [2:0] EV_BREAK   = 3'd4;
    localparam logic [2:0] EV_CACK    = 3'd5;
    localparam logic [2:0] EV_CNAK    = 3'd6;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DIGIT1  = 2'd2;
    localparam logic [1:0] PH_DIGIT2  = 2'd3;

    localparam logic [7:0] CH_BREAK = 8'h03;
    localparam logic [7:0] CH_OPEN  = 8'h24;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0]  REG_ACK_ENABLE = 1'd0;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] payload_byte;
        logic [7:0] packet_sum;
        logic       ack_valid;
        logic [7:0] ack_byte;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        logic [7:0] d;
        h = '0;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            h.ok = 1'b1;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            h.ok = 1'b1;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            h.ok = 1'b1;
        end
        h.value = d[3:0];
        return h;
    endfunction

endpackage

// ===== sv/rpd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_cfg_regs
// APB-style register file holding the ack enable bit.
// ----------------------------------------------------------------------------
module rpd_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic                        ack_enable
);

    logic ack_enable_reg;
    logic ack_enable_next;
    logic hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2:2] == rpd_pkg::REG_ACK_ENABLE);

    always_comb
    begin
        ack_enable_next = ack_enable_reg;
        if (psel && penable && pwrite && hit)
        begin
            ack_enable_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_enable_reg <= 1'b1;
        end
        else
        begin
            ack_enable_reg <= ack_enable_next;
        end
    end

    assign prdata     = hit ? {31'd0, ack_enable_reg} : 32'd0;
    assign ack_enable = ack_enable_reg;

endmodule

// ===== sv/rpd_frame_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_frame_engine
// Packet phase tracking, checksum compare and result register.
// ----------------------------------------------------------------------------
module rpd_frame_engine
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic [7:0]    rx_byte,
    input  logic          ack_enable,
    output rpd_pkg::res_t res
);

    logic [1:0]    phase_reg;
    logic [1:0]    phase_next;
    logic [7:0]    sum_reg;
    logic [7:0]    sum_next;
    logic [3:0]    digit_reg;
    logic [3:0]    digit_next;
    logic          digit_ok_reg;
    logic          digit_ok_next;
    rpd_pkg::res_t res_reg;
    rpd_pkg::res_t res_next;
    rpd_pkg::hex_t hex;

    assign hex = rpd_pkg::hex_decode(rx_byte);

    always_comb
    begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        digit_next    = digit_reg;
        digit_ok_next = digit_ok_reg;
        res_next      = '0;
        unique case (phase_reg)
            rpd_pkg::PH_IDLE:
            begin
                if (rx_byte == rpd_pkg::CH_PLUS)
                begin
                    res_next.event_res = rpd_pkg::EV_CACK;
                end
                else if (rx_byte == rpd_pkg::CH_MINUS)
                begin
                    res_next.event_res = rpd_pkg::EV_CNAK;
                end
                else if (rx_byte == rpd_pkg::CH_BREAK)
                begin
                    res_next.event_res = rpd_pkg::EV_BREAK;
                    res_next.ack_valid = ack_enable;
                    res_next.ack_byte  = ack_enable ? rpd_pkg::CH_PLUS : 8'd0;
                end
                else if (rx_byte == rpd_pkg::CH_OPEN)
                begin
                    phase_next = rpd_pkg::PH_PAYLOAD;
                    sum_next   = 8'd0;
                end
            end
            rpd_pkg::PH_PAYLOAD:
            begin
                if (rx_byte == rpd_pkg::CH_HASH)
                begin
                    phase_next = rpd_pkg::PH_DIGIT1;
                end
                else
                begin
                    res_next.event_res    = rpd_pkg::EV_PAYLOAD;
                    res_next.payload_byte = rx_byte;
                    sum_next              = sum_reg + rx_byte;
                end
            end
            rpd_pkg::PH_DIGIT1:
            begin
                digit_next    = hex.value;
                digit_ok_next = hex.ok;
                phase_next    = rpd_pkg::PH_DIGIT2;
            end
            rpd_pkg::PH_DIGIT2:
            begin
                res_next.packet_sum = sum_reg;
                res_next.ack_valid  = ack_enable;
                if (hex.ok && digit_ok_reg && ({digit_reg, hex.value} == sum_reg))
                begin
                    res_next.event_res = rpd_pkg::EV_GOOD;
                    res_next.ack_byte  = ack_enable ? rpd_pkg::CH_PLUS : 8'd0;
                end
                else
                begin
                    res_next.event_res = rpd_pkg::EV_BAD;
                    res_next.ack_byte  = ack_enable ? rpd_pkg::CH_MINUS : 8'd0;
                end
                phase_next = rpd_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = rpd_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rpd_pkg::PH_IDLE;
            sum_reg      <= 8'd0;
            digit_reg    <= 4'd0;
            digit_ok_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            digit_reg    <= digit_next;
            digit_ok_reg <= digit_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== sv/rsp_packet_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_packet_deframer
// Byte-serial deframer for debug-link packets with a modulo-256 checksum.
// ----------------------------------------------------------------------------
// Input channel: one received character per transaction on rx_byte, with
// in_valid / in_stall. Output channel: one result transaction per input
// transaction, with out_valid / out_stall, carrying event_res, payload_byte,
// packet_sum, ack_valid and ack_byte.
// A character lands in the input register at the edge it is taken; its result
// is written to the result register, raising out_valid, once that register is
// empty or its result is being taken.
// Throughput is one character per cycle while the receiver does not stall; the
// frame engine's single phase/sum update per cycle sets that figure.
// When the receiver stalls, the result register holds, the input register
// holds one more character, and in_stall rises once both are full.
// Reset empties both registers, returns to the idle phase outside any
// packet with a zero sum, and sets ack_enable. ack_enable sits at byte
// address 0 of the APB port; write it only while the block is idle.
// ----------------------------------------------------------------------------
module rsp_packet_deframer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rpd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  event_res,
    output logic [7:0]                  payload_byte,
    output logic [7:0]                  packet_sum,
    output logic                        ack_valid,
    output logic [7:0]                  ack_byte
);

    logic          ack_enable;
    logic          hold_valid_reg;
    logic          hold_valid_next;
    logic [7:0]    hold_byte_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          advance;
    logic          take;
    rpd_pkg::res_t res;

    rpd_cfg_regs u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .ack_enable (ack_enable)
    );

    // advance the held character when the result register frees up
    assign advance  = hold_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = hold_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_byte_reg <= rx_byte;
        end
    end

    rpd_frame_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .rx_byte    (hold_byte_reg),
        .ack_enable (ack_enable),
        .res        (res)
    );

    assign out_valid    = out_valid_reg;
    assign event_res    = res.event_res;
    assign payload_byte = res.payload_byte;
    assign packet_sum   = res.packet_sum;
    assign ack_valid    = res.ack_valid;
    assign ack_byte     = res.ack_byte;

endmodule

// ===== sv/rpd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
`include "rsp_packet_deframer_defines.svh"

module rpd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] event_res,
    input logic [7:0] payload_byte,
    input logic [7:0] packet_sum,
    input logic       ack_valid,
    input logic [7:0] ack_byte
);

    `RPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(event_res) && $stable(packet_sum))
    `RPD_ASSERT_IMPLY(a_ack_event, clk, rst_n, out_valid && ack_valid, event_res == rpd_pkg::EV_GOOD || event_res == rpd_pkg::EV_BAD || event_res == rpd_pkg::EV_BREAK)
    `RPD_ASSERT_IMPLY(a_nak_byte, clk, rst_n, out_valid && ack_valid && event_res == rpd_pkg::EV_BAD, ack_byte == rpd_pkg::CH_MINUS)
    `RPD_ASSERT_IMPLY(a_payload_only, clk, rst_n, out_valid && event_res != rpd_pkg::EV_PAYLOAD, payload_byte == 8'd0)
    `RPD_ASSERT_IMPLY(a_no_ack_byte, clk, rst_n, out_valid && !ack_valid, ack_byte == 8'd0)

endmodule

bind rsp_packet_deframer rpd_checker u_rpd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .payload_byte (payload_byte),
    .packet_sum   (packet_sum),
    .ack_valid    (ack_valid),
    .ack_byte     (ack_byte)
);

// ===== verif/rsp_packet_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_packet_deframer_tb
// Self-checking testbench for the debug-link packet deframer.
// ----------------------------------------------------------------------------
// Drives received characters through the valid/stall input channel and keeps
// a cycle-free model of the framing state, the running checksum and the ack
// mode. Every character accepted queues one expected result; each result
// taken from the output channel is compared field by field with the oldest
// one. Directed frames cover the idle control characters, empty and control-
// laden packets and a malformed checksum. Random traffic then runs mostly
// well-formed packets with random bodies, mixed with noise, with acks on and
// off under four sender gap / receiver stall mixes; a separate test holds the
// receiver long enough to back the block up.
// ----------------------------------------------------------------------------
module rsp_packet_deframer_tb;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int QUIET_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 190;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;

    localparam logic [rpd_pkg::PADDR_W-1:0] ADDR_ACK_ENABLE =
        {rpd_pkg::REG_ACK_ENABLE, 2'b00};
    localparam logic [rpd_pkg::PADDR_W-1:0] ADDR_UNUSED     = 3'd4;

    typedef enum logic [1:0] {CK_GOOD, CK_WRONG, CK_JUNK_HI, CK_JUNK_LO} check_kind_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         psel         = 1'b0;
    logic                         penable      = 1'b0;
    logic                         pwrite       = 1'b0;
    logic [rpd_pkg::PADDR_W-1:0]  paddr        = '0;
    logic [31:0]                  pwdata       = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         in_valid     = 1'b0;
    logic                         in_stall;
    logic [7:0]                   rx_byte      = '0;
    logic                         out_valid;
    logic                         out_stall    = 1'b0;
    logic [2:0]                   event_res;
    logic [7:0]                   payload_byte;
    logic [7:0]                   packet_sum;
    logic                         ack_valid;
    logic [7:0]                   ack_byte;

    // frame model
    logic [1:0] frame_phase  = rpd_pkg::PH_IDLE;
    logic [7:0] frame_sum    = 8'd0;
    logic [3:0] high_digit   = 4'd0;
    logic       high_digit_ok = 1'b0;
    logic       acks_on      = 1'b1;

    rpd_pkg::res_t expected_q[$];
    logic [7:0]    frame_body[$];

    int gap_pct        = 0;
    int stall_pct      = 0;
    int hold_req       = 0;
    int mismatches     = 0;
    int bytes_sent     = 0;
    int useful_bytes   = 0;
    int results_checked = 0;
    int packets_good   = 0;
    int packets_bad    = 0;
    int breaks_seen    = 0;
    int ack_switches   = 0;

    rsp_packet_deframer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .payload_byte (payload_byte),
        .packet_sum   (packet_sum),
        .ack_valid    (ack_valid),
        .ack_byte     (ack_byte)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        if (c >= "0" && c <= "9")
        begin
            d = c - "0";
            return {1'b1, d[3:0]};
        end
        if (c >= "a" && c <= "f")
        begin
            d = c - "a" + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= "A" && c <= "F")
        begin
            d = c - "A" + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic rpd_pkg::res_t deframe_step(input logic [7:0] c);
        rpd_pkg::res_t r;
        logic [4:0]    h;
        r = '0;
        case (frame_phase)
            rpd_pkg::PH_IDLE:
            begin
                if (c == rpd_pkg::CH_PLUS)
                    r.event_res = rpd_pkg::EV_CACK;
                else if (c == rpd_pkg::CH_MINUS)
                    r.event_res = rpd_pkg::EV_CNAK;
                else if (c == rpd_pkg::CH_BREAK)
                begin
                    r.event_res = rpd_pkg::EV_BREAK;
                    r.ack_valid = acks_on;
                    r.ack_byte  = acks_on ? rpd_pkg::CH_PLUS : 8'd0;
                end
                else if (c == rpd_pkg::CH_OPEN)
                begin
                    frame_phase = rpd_pkg::PH_PAYLOAD;
                    frame_sum   = 8'd0;
                end
            end
            rpd_pkg::PH_PAYLOAD:
            begin
                if (c == rpd_pkg::CH_HASH)
                    frame_phase = rpd_pkg::PH_DIGIT1;
                else
                begin
                    r.event_res    = rpd_pkg::EV_PAYLOAD;
                    r.payload_byte = c;
                    frame_sum      = frame_sum + c;
                end
            end
            rpd_pkg::PH_DIGIT1:
            begin
                h = hex_digit(c);
                high_digit    = h[3:0];
                high_digit_ok = h[4];
                frame_phase   = rpd_pkg::PH_DIGIT2;
            end
            default:
            begin
                h = hex_digit(c);
                r.packet_sum = frame_sum;
                if (h[4] && high_digit_ok && {high_digit, h[3:0]} == frame_sum)
                begin
                    r.event_res = rpd_pkg::EV_GOOD;
                    r.ack_byte  = rpd_pkg::CH_PLUS;
                end
                else
                begin
                    r.event_res = rpd_pkg::EV_BAD;
                    r.ack_byte  = rpd_pkg::CH_MINUS;
                end
                r.ack_valid = acks_on;
                if (!acks_on)
                    r.ack_byte = 8'd0;
                frame_phase = rpd_pkg::PH_IDLE;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        if (n < 4'd10)
            return "0" + n;
        base = $urandom_range(0, 1) ? "A" : "a";
        return base + n - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [4:0] h;
        do
        begin
            c = 8'($urandom_range(0, 255));
            h = hex_digit(c);
        end
        while (h[4]);
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] c);
        rpd_pkg::res_t r;
        logic [1:0]    ph;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ph = frame_phase;
        r  = deframe_step(c);
        expected_q.push_back(r);
        bytes_sent++;
        if (!(ph == rpd_pkg::PH_IDLE && r.event_res == rpd_pkg::EV_NONE &&
              c != rpd_pkg::CH_OPEN))
            useful_bytes++;
        case (r.event_res)
            rpd_pkg::EV_GOOD:  packets_good++;
            rpd_pkg::EV_BAD:   packets_bad++;
            rpd_pkg::EV_BREAK: breaks_seen++;
            default:  ;
        endcase
    endtask

    task automatic send_packet(input check_kind_t kind);
        logic [7:0] sum;
        logic [7:0] flip;
        logic [7:0] hi_c;
        logic [7:0] lo_c;
        sum = 8'd0;
        send_byte(rpd_pkg::CH_OPEN);
        foreach (frame_body[i])
        begin
            send_byte(frame_body[i]);
            sum = sum + frame_body[i];
        end
        send_byte(rpd_pkg::CH_HASH);
        if (kind == CK_WRONG)
        begin
            flip = 8'($urandom_range(1, 255));
            sum  = sum ^ flip;
        end
        hi_c = hex_char(sum[7:4]);
        lo_c = hex_char(sum[3:0]);
        if (kind == CK_JUNK_HI)
            hi_c = non_hex_char();
        if (kind == CK_JUNK_LO)
            lo_c = non_hex_char();
        send_byte(hi_c);
        send_byte(lo_c);
    endtask

    task automatic fill_random_body(input int len);
        logic [7:0] b;
        frame_body.delete();
        repeat (len)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == rpd_pkg::CH_HASH)
                b = rpd_pkg::CH_OPEN;
            frame_body.push_back(b);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [rpd_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ACK_ENABLE)
        begin
            if (acks_on != data[0])
                ack_switches++;
            acks_on = data[0];
        end
    endtask

    task automatic report_mismatch(input string what, input rpd_pkg::res_t want,
                                   input rpd_pkg::res_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected ev=%0d pay=%02h sum=%02h ack=%0b/%02h, got ev=%0d pay=%02h sum=%02h ack=%0b/%02h",
                     $realtime, what,
                     want.event_res, want.payload_byte, want.packet_sum,
                     want.ack_valid, want.ack_byte,
                     got.event_res, got.payload_byte, got.packet_sum,
                     got.ack_valid, got.ack_byte);
    endtask

    always @(posedge clk)
    begin : result_check
        rpd_pkg::res_t got;
        rpd_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {event_res, payload_byte, packet_sum, ack_valid, ack_byte};
            results_checked++;
            if (expected_q.size() == 0)
                report_mismatch("result with nothing pending", '0, got);
            else
            begin
                want = expected_q.pop_front();
                if (got.event_res !== want.event_res ||
                    got.payload_byte !== want.payload_byte ||
                    got.packet_sum !== want.packet_sum ||
                    got.ack_valid !== want.ack_valid ||
                    got.ack_byte !== want.ack_byte)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    initial
    begin : receiver
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                n        = hold_req;
                hold_req = 0;
                out_stall <= 1'b1;
                repeat (n - 1)
                    @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transaction for %0d cycles", QUIET_LIMIT);
        $display("rsp_packet_deframer verification failed");
        $finish;
    end

    task automatic test_directed_frames();
        send_byte(rpd_pkg::CH_PLUS);
        send_byte(rpd_pkg::CH_MINUS);
        send_byte(rpd_pkg::CH_BREAK);
        send_byte(8'h00);
        send_byte(8'hFF);
        frame_body.delete();
        send_packet(CK_GOOD);
        frame_body = '{8'h00, 8'hFF, rpd_pkg::CH_OPEN, rpd_pkg::CH_PLUS,
                       rpd_pkg::CH_MINUS, rpd_pkg::CH_BREAK};
        send_packet(CK_GOOD);
        frame_body.delete();
        send_packet(CK_JUNK_HI);
    endtask

    task automatic test_ack_modes();
        write_reg(ADDR_UNUSED, 32'hFFFF_FFFE);
        send_byte(rpd_pkg::CH_BREAK);
        write_reg(ADDR_ACK_ENABLE, 32'd0);
        send_byte(rpd_pkg::CH_BREAK);
        frame_body.delete();
        send_packet(CK_GOOD);
        send_packet(CK_WRONG);
        write_reg(ADDR_ACK_ENABLE, 32'd1);
    endtask

    task automatic test_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        hold_req  = HOLD_CYCLES;
        fill_random_body(30);
        send_packet(CK_GOOD);
        // hold the sender until the block has emptied
        wait_drained();
        fill_random_body(5);
        send_packet(CK_GOOD);
    endtask

    task automatic test_random_traffic();
        int          ack_mix[4]   = '{1, 0, 1, 0};
        int          gap_mix[4]   = '{0, 45, 0, 9};
        int          stall_mix[4] = '{0, 0, 45, 9};
        int          target;
        int          pick;
        int          len;
        check_kind_t kind;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(ADDR_ACK_ENABLE, ack_mix[p]);
            gap_pct   = gap_mix[p];
            stall_pct = stall_mix[p];
            target    = useful_bytes + PHASE_ITEMS;
            while (useful_bytes < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                      : $urandom_range(0, 12);
                    fill_random_body(len);
                    pick = $urandom_range(0, 99);
                    kind = (pick < 75) ? CK_GOOD :
                           (pick < 85) ? CK_WRONG :
                           (pick < 93) ? CK_JUNK_HI : CK_JUNK_LO;
                    send_packet(kind);
                end
                else if (pick < 85)
                begin
                    pick = $urandom_range(0, 2);
                    send_byte(pick == 0 ? rpd_pkg::CH_PLUS :
                              pick == 1 ? rpd_pkg::CH_MINUS : rpd_pkg::CH_BREAK);
                end
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin : test_sequence
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_ack_modes();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d bytes sent, %0d results checked: %0d packets good, %0d bad, %0d breaks",
                 bytes_sent, results_checked, packets_good, packets_bad, breaks_seen);
        $display("ack mode switched %0d times over four gap/stall mixes and a long receiver hold",
                 ack_switches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("rsp_packet_deframer verification clean");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches, expected_q.size());
            $display("rsp_packet_deframer verification failed");
        end
        $finish;
    end

endmodule
